// ----- design/glrm_pkg.sv -----
// Shared types, register codes and helpers for the glyph run line box merger.
package glrm_pkg;

    localparam int COORD_W     = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [COORD_W-1:0] MAX15 = COORD_W'(32767);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MEDIA_LEFT   = 3'd0,
        CFG_MEDIA_TOP    = 3'd1,
        CFG_MEDIA_WIDTH  = 3'd2,
        CFG_MEDIA_HEIGHT = 3'd3,
        CFG_PAGE_NUMBER  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] glyph_x;
        logic [15:0] glyph_y;
        logic [14:0] glyph_w;
        logic [14:0] glyph_h;
        logic        lookahead_only;
        logic        last_glyph;
    } glyph_t;

    typedef struct packed {
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [14:0] rect_w;
        logic [14:0] rect_h;
        logic [15:0] rect_page;
        logic        rect_valid;
        logic        end_of_range;
    } rect_t;

    // x/y are signed, w/h unsigned
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
    } box_t;

    typedef struct packed {
        logic en;
        logic clip;
    } flush_ctrl_t;

    function automatic logic signed [COORD_W-1:0] sx16(input logic [15:0] v);
        sx16 = {{(COORD_W-16){v[15]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] zx15(input logic [14:0] v);
        zx15 = {{(COORD_W-15){1'b0}}, v};
    endfunction

endpackage

// ----- design/glrm_flush.sv -----
// Run flush: media box intersection, empty check and clip at the ending glyph.
module glrm_flush (
    input  glrm_pkg::box_t        run,
    input  glrm_pkg::box_t        media,
    input  glrm_pkg::box_t        glyph,
    input  glrm_pkg::flush_ctrl_t ctrl,
    output logic                  emit,
    output glrm_pkg::box_t        rect
);

    logic signed [glrm_pkg::COORD_W-1:0] rl, rt, rr, rb;
    logic signed [glrm_pkg::COORD_W-1:0] ml, mt, mr, mb;
    logic signed [glrm_pkg::COORD_W-1:0] l, t, r, b;
    logic signed [glrm_pkg::COORD_W-1:0] cx, cy, cb, w, h;
    logic run_open, is_break, clip;

    always_comb
    begin
        rl = glrm_pkg::sx16(run.x);
        rt = glrm_pkg::sx16(run.y);
        rr = rl + glrm_pkg::zx15(run.w);
        rb = rt + glrm_pkg::zx15(run.h);
        ml = glrm_pkg::sx16(media.x);
        mt = glrm_pkg::sx16(media.y);
        mr = ml + glrm_pkg::zx15(media.w);
        mb = mt + glrm_pkg::zx15(media.h);
        cx = glrm_pkg::sx16(glyph.x);
        cy = glrm_pkg::sx16(glyph.y);
        cb = cy + glrm_pkg::zx15(glyph.h);

        l = (rl > ml) ? rl : ml;
        t = (rt > mt) ? rt : mt;
        r = (rr < mr) ? rr : mr;
        b = (rb < mb) ? rb : mb;

        run_open = (run.w != '0) && (run.h != '0);
        is_break = (glyph.x == '0) && (glyph.w == '0);
        emit     = ctrl.en && run_open && (r > l) && (b > t);

        // ending glyph must overlap vertically and start strictly inside
        clip = ctrl.clip && !is_break && (cy < b) && (cb > t) && (l < cx) && (r > cx);
        w    = clip ? (cx - l) : (r - l);
        h    = b - t;

        rect.x = l[15:0];
        rect.y = t[15:0];
        rect.w = w[14:0];
        rect.h = h[14:0];
    end

endmodule

// ----- design/glrm_queue.sv -----
// Result queue: takes up to two beats a cycle, hands out one.
module glrm_queue #(
    parameter int DEPTH = glrm_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push_cnt,
    input  glrm_pkg::rect_t push_first,
    input  glrm_pkg::rect_t push_second,
    input  logic            pop,
    output logic            room,
    output logic            out_valid,
    output glrm_pkg::rect_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    glrm_pkg::rect_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_second;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_second = ptr_inc(wr_ptr_reg);
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_second;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_second);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
        room        = (count_reg <= CW'(DEPTH - 2));
        out_valid   = (count_reg != '0);
        out_data    = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_second] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

endmodule

// ----- design/glyph_run_line_box_merger.sv -----
// Top level of the glyph run line box merger.
//
//   port group   dir   beat moves
//   glyph_*      in    one glyph box with look-ahead and last flags
//   line_*       out   one line rectangle or end marker
//   cfg_*        in    register write, no handshake
//
// One glyph per cycle while glyph_stall is low; a beat is held in the item
// register and its results reach the line port through the result queue.
// A final glyph can yield two rectangles; both enter the queue together and leave it one at a time.
// glyph_stall rises while the item register is held because the result
// queue has fewer than two free slots.
// Reset clears the run box, the media box, the page number and the queue.
module glyph_run_line_box_merger #(
    parameter int QUEUE_DEPTH = glrm_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             glyph_valid,
    output logic                             glyph_stall,
    input  glrm_pkg::glyph_t                 glyph,
    output logic                             line_valid,
    input  logic                             line_stall,
    output glrm_pkg::rect_t                  line,
    input  logic                             cfg_write,
    input  logic [glrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);

    glrm_pkg::glyph_t item_reg, item_next;
    logic             item_valid_reg, item_valid_next;
    glrm_pkg::box_t   run_reg, run_next;
    glrm_pkg::box_t   media_reg, media_next;
    logic [15:0]      page_reg, page_next;

    logic accept, take, room, pop;

    logic signed [glrm_pkg::COORD_W-1:0] gx, gy, gw, gh, gr, gb;
    logic signed [glrm_pkg::COORD_W-1:0] rx, ry, rr, rb;
    logic signed [glrm_pkg::COORD_W-1:0] ov_top, ov_bot;
    logic signed [glrm_pkg::COORD_W-1:0] mg_l, mg_t, mg_r, mg_b, mg_w, mg_h;
    logic run_open, is_break, look, last_item, final_item, thin;

    glrm_pkg::box_t        glyph_box, merged, new_run, rect1, rect2;
    glrm_pkg::flush_ctrl_t f1_ctrl, f2_ctrl;
    logic                  f1_emit, f2_emit;

    logic [1:0]      push_cnt;
    glrm_pkg::rect_t push_first, push_second, res1, res2, marker;

    // input side
    always_comb
    begin
        take        = item_valid_reg && room;
        glyph_stall = item_valid_reg && !room;
        accept      = glyph_valid && !glyph_stall;
        item_next   = accept ? glyph : item_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    // configuration
    always_comb
    begin
        media_next = media_reg;
        page_next  = page_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                glrm_pkg::CFG_MEDIA_LEFT:   media_next.x = cfg_data;
                glrm_pkg::CFG_MEDIA_TOP:    media_next.y = cfg_data;
                glrm_pkg::CFG_MEDIA_WIDTH:  media_next.w = cfg_data[14:0];
                glrm_pkg::CFG_MEDIA_HEIGHT: media_next.h = cfg_data[14:0];
                glrm_pkg::CFG_PAGE_NUMBER:  page_next    = cfg_data;
                default:                    ;
            endcase
        end
    end

    // line test and merge against the open run
    always_comb
    begin
        gx = glrm_pkg::sx16(item_reg.glyph_x);
        gy = glrm_pkg::sx16(item_reg.glyph_y);
        gw = glrm_pkg::zx15(item_reg.glyph_w);
        gh = glrm_pkg::zx15(item_reg.glyph_h);
        gr = gx + gw;
        gb = gy + gh;
        rx = glrm_pkg::sx16(run_reg.x);
        ry = glrm_pkg::sx16(run_reg.y);
        rr = rx + glrm_pkg::zx15(run_reg.w);
        rb = ry + glrm_pkg::zx15(run_reg.h);

        run_open   = (run_reg.w != '0) && (run_reg.h != '0);
        is_break   = (item_reg.glyph_x == '0) && (item_reg.glyph_w == '0);
        look       = item_reg.lookahead_only;
        last_item  = item_reg.last_glyph;
        final_item = look || last_item;

        ov_top = (ry > gy) ? ry : gy;
        ov_bot = (rb < gb) ? rb : gb;
        thin   = ((ov_bot - ov_top) <<< 1) < gh;

        mg_l = (rx < gx) ? rx : gx;
        mg_t = (ry < gy) ? ry : gy;
        mg_r = (rr > gr) ? rr : gr;
        mg_b = (rb > gb) ? rb : gb;
        mg_w = mg_r - mg_l;
        mg_h = mg_b - mg_t;

        glyph_box.x = item_reg.glyph_x;
        glyph_box.y = item_reg.glyph_y;
        glyph_box.w = item_reg.glyph_w;
        glyph_box.h = item_reg.glyph_h;

        merged.x = mg_l[15:0];
        merged.y = mg_t[15:0];
        merged.w = (mg_w > glrm_pkg::MAX15) ? 15'h7fff : mg_w[14:0];
        merged.h = (mg_h > glrm_pkg::MAX15) ? 15'h7fff : mg_h[14:0];

        // first flush closes the old run, second one flushes what is left at range end
        f1_ctrl.en   = look || is_break || (run_open && thin);
        f1_ctrl.clip = look || !is_break;
        f2_ctrl.en   = last_item && !look;
        f2_ctrl.clip = 1'b0;

        if (look || is_break)
        begin
            new_run = '0;
        end
        else if (!run_open || thin)
        begin
            new_run = glyph_box;
        end
        else if ((gw != '0) && (gh != '0))
        begin
            new_run = merged;
        end
        else
        begin
            new_run = run_reg;
        end

        if (take)
        begin
            run_next = final_item ? '0 : new_run;
        end
        else
        begin
            run_next = run_reg;
        end
    end

    glrm_flush u_flush_old (
        .run   (run_reg),
        .media (media_reg),
        .glyph (glyph_box),
        .ctrl  (f1_ctrl),
        .emit  (f1_emit),
        .rect  (rect1)
    );

    glrm_flush u_flush_end (
        .run   (new_run),
        .media (media_reg),
        .glyph (glyph_box),
        .ctrl  (f2_ctrl),
        .emit  (f2_emit),
        .rect  (rect2)
    );

    // result beats
    always_comb
    begin
        res1 = '{rect_x: rect1.x, rect_y: rect1.y, rect_w: rect1.w, rect_h: rect1.h,
                 rect_page: page_reg, rect_valid: 1'b1, end_of_range: 1'b0};
        res2 = '{rect_x: rect2.x, rect_y: rect2.y, rect_w: rect2.w, rect_h: rect2.h,
                 rect_page: page_reg, rect_valid: 1'b1, end_of_range: 1'b0};
        marker              = '0;
        marker.end_of_range = 1'b1;

        if (f1_emit)
        begin
            push_first = res1;
        end
        else if (f2_emit)
        begin
            push_first = res2;
        end
        else
        begin
            push_first = marker;
        end
        push_first.end_of_range = final_item && !(f1_emit && f2_emit);

        push_second              = res2;
        push_second.end_of_range = final_item;

        if (!take)
        begin
            push_cnt = 2'd0;
        end
        else if (f1_emit && f2_emit)
        begin
            push_cnt = 2'd2;
        end
        else if (f1_emit || f2_emit || final_item)
        begin
            push_cnt = 2'd1;
        end
        else
        begin
            push_cnt = 2'd0;
        end

        pop = line_valid && !line_stall;
    end

    glrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push_first  (push_first),
        .push_second (push_second),
        .pop         (pop),
        .room        (room),
        .out_valid   (line_valid),
        .out_data    (line)
    );

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            run_reg        <= '0;
            media_reg      <= '0;
            page_reg       <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            run_reg        <= run_next;
            media_reg      <= media_next;
            page_reg       <= page_next;
        end
    end

    // range end always leaves no open run
    assert property (@(posedge clk) disable iff (!rst_n)
        take && final_item |=> (run_reg.w == '0) && (run_reg.h == '0))
        else $error("run left open after range end");

    // a pair of beats only comes from a final item, and only the second ends it
    assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> final_item && push_second.end_of_range
                             && !push_first.end_of_range)
        else $error("bad end flag on result pair");

    // emitted rectangles are never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && line.rect_valid |-> (line.rect_w != '0) && (line.rect_h != '0))
        else $error("empty rectangle emitted");

    // end marker carries nothing but the end flag
    assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line.rect_valid |-> line.end_of_range && (line.rect_page == '0)
                                           && (line.rect_w == '0) && (line.rect_x == '0))
        else $error("malformed end marker");

endmodule

// ----- dv/glrm_checker.sv -----
// Checker for the glyph run line box merger: predicts line beats and compares them.
module glrm_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             glyph_valid,
    input  logic                             glyph_stall,
    input  glrm_pkg::glyph_t                 glyph,
    input  logic                             line_valid,
    input  logic                             line_stall,
    input  glrm_pkg::rect_t                  line,
    input  logic                             cfg_write,
    input  logic [glrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output int                               mismatches,
    output int                               outstanding
);

    int          media_left;
    int          media_top;
    int          media_width;
    int          media_height;
    logic [15:0] page_number;

    int          box_left;
    int          box_top;
    int          box_width;
    int          box_height;

    glrm_pkg::rect_t step_lines[2];
    int              step_count;
    glrm_pkg::rect_t expected_lines[$];
    int              fail_total = 0;

    function automatic int bigger(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int smaller(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic void load_box(input int x, input int y, input int w, input int h);
        box_left   = x;
        box_top    = y;
        box_width  = w;
        box_height = h;
    endfunction

    // Close the open box against the media box; with clip set, cut it at the x of
    // the glyph that ended it when that glyph overlaps it and starts inside it.
    function automatic void flush_box(input bit clip, input int cx, input int cy,
                                      input int cw, input int ch);
        int              l;
        int              t;
        int              r;
        int              b;
        int              w;
        int              h;
        glrm_pkg::rect_t rc;
        if (box_width == 0 || box_height == 0)
            return;
        l = bigger(box_left, media_left);
        t = bigger(box_top, media_top);
        r = smaller(box_left + box_width, media_left + media_width);
        b = smaller(box_top + box_height, media_top + media_height);
        if (r <= l || b <= t)
            return;
        w = r - l;
        h = b - t;
        if (clip && (cx != 0 || cw != 0) && cy < t + h && cy + ch > t &&
            l < cx && l + w > cx)
            w = cx - l;
        rc              = '0;
        rc.rect_x       = l[15:0];
        rc.rect_y       = t[15:0];
        rc.rect_w       = w[14:0];
        rc.rect_h       = h[14:0];
        rc.rect_page    = page_number;
        rc.rect_valid   = 1'b1;
        step_lines[step_count] = rc;
        step_count++;
    endfunction

    function automatic void predict_glyph(input glrm_pkg::glyph_t g);
        int gx;
        int gy;
        int gw;
        int gh;
        int top;
        int bot;
        int l;
        int t;
        int r;
        int b;
        bit look;
        gx   = int'($signed(g.glyph_x));
        gy   = int'($signed(g.glyph_y));
        gw   = int'(g.glyph_w);
        gh   = int'(g.glyph_h);
        look = g.lookahead_only;
        step_count = 0;

        if (look) begin
            flush_box(1'b1, gx, gy, gw, gh);
            load_box(0, 0, 0, 0);
        end
        else if (gx == 0 && gw == 0) begin
            flush_box(1'b0, 0, 0, 0, 0);
            load_box(0, 0, 0, 0);
        end
        else if (box_width == 0 || box_height == 0) begin
            load_box(gx, gy, gw, gh);
        end
        else begin
            top = bigger(box_top, gy);
            bot = smaller(box_top + box_height, gy + gh);
            if ((bot - top) * 2 < gh) begin
                flush_box(1'b1, gx, gy, gw, gh);
                load_box(gx, gy, gw, gh);
            end
            else if (gw != 0 && gh != 0) begin
                l = smaller(box_left, gx);
                t = smaller(box_top, gy);
                r = bigger(box_left + box_width, gx + gw);
                b = bigger(box_top + box_height, gy + gh);
                // width and height saturate at the 15-bit limit
                load_box(l, t, smaller(r - l, 32767), smaller(b - t, 32767));
            end
        end

        if (look || g.last_glyph) begin
            if (!look) begin
                flush_box(1'b0, 0, 0, 0, 0);
                load_box(0, 0, 0, 0);
            end
            if (step_count == 0) begin
                step_lines[0] = '0;
                step_count    = 1;
            end
            step_lines[step_count-1].end_of_range = 1'b1;
        end

        for (int i = 0; i < step_count; i++)
            expected_lines.push_back(step_lines[i]);
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        glrm_pkg::rect_t want;
        if (!rst_n) begin
            media_left   = 0;
            media_top    = 0;
            media_width  = 0;
            media_height = 0;
            page_number  = '0;
            load_box(0, 0, 0, 0);
            expected_lines.delete();
            outstanding <= 0;
            mismatches  <= fail_total;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    glrm_pkg::CFG_MEDIA_LEFT:   media_left   = int'($signed(cfg_data));
                    glrm_pkg::CFG_MEDIA_TOP:    media_top    = int'($signed(cfg_data));
                    glrm_pkg::CFG_MEDIA_WIDTH:  media_width  = int'(cfg_data[14:0]);
                    glrm_pkg::CFG_MEDIA_HEIGHT: media_height = int'(cfg_data[14:0]);
                    glrm_pkg::CFG_PAGE_NUMBER:  page_number  = cfg_data;
                    default: ;
                endcase
            end

            if (line_valid && !line_stall) begin
                if (expected_lines.size() == 0) begin
                    $error("unexpected line beat: x %0d y %0d w %0d h %0d end %0b",
                           $signed(line.rect_x), $signed(line.rect_y), line.rect_w,
                           line.rect_h, line.end_of_range);
                    fail_total++;
                end
                else begin
                    want = expected_lines.pop_front();
                    check_field("rect_x", $signed(want.rect_x), $signed(line.rect_x));
                    check_field("rect_y", $signed(want.rect_y), $signed(line.rect_y));
                    check_field("rect_w", want.rect_w, line.rect_w);
                    check_field("rect_h", want.rect_h, line.rect_h);
                    check_field("rect_page", want.rect_page, line.rect_page);
                    check_field("rect_valid", want.rect_valid, line.rect_valid);
                    check_field("end_of_range", want.end_of_range, line.end_of_range);
                end
            end

            if (glyph_valid && !glyph_stall)
                predict_glyph(glyph);

            outstanding <= expected_lines.size();
            mismatches  <= fail_total;
        end
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives glyph beats and register writes into the line box merger.
module tb;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             glyph_valid = 1'b0;
    logic                             glyph_stall;
    glrm_pkg::glyph_t                 glyph       = '0;
    logic                             line_valid;
    logic                             line_stall  = 1'b0;
    glrm_pkg::rect_t                  line;
    logic                             cfg_write   = 1'b0;
    logic [glrm_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [15:0]                      cfg_data    = '0;
    int                               mismatches;
    int                               outstanding;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    // local copy of the media box left and top, used to aim glyphs at the page
    int page_left      = 0;
    int page_top       = 0;

    glyph_run_line_box_merger u_dut (.*);
    glrm_checker u_checker (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        line_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic send_glyph(input glrm_pkg::glyph_t g);
        while ($urandom_range(99) < send_idle_pct) begin
            glyph_valid <= 1'b0;
            @(posedge clk);
        end
        glyph_valid <= 1'b1;
        glyph       <= g;
        do
            @(posedge clk);
        while (glyph_stall);
        beats_sent++;
    endtask

    task automatic send_box(input int x, input int y, input int w, input int h,
                            input bit look = 1'b0, input bit last = 1'b0);
        glrm_pkg::glyph_t g;
        g.glyph_x        = x[15:0];
        g.glyph_y        = y[15:0];
        g.glyph_w        = w[14:0];
        g.glyph_h        = h[14:0];
        g.lookahead_only = look;
        g.last_glyph     = last;
        send_glyph(g);
    endtask

    // Let the block go quiet: no beat in flight and every line beat delivered.
    task automatic wait_idle();
        glyph_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_page(input int left, input int top, input int w, input int h,
                            input logic [15:0] page);
        cfg_write <= 1'b1;
        cfg_index <= glrm_pkg::CFG_MEDIA_LEFT;
        cfg_data  <= left[15:0];
        @(posedge clk);
        cfg_index <= glrm_pkg::CFG_MEDIA_TOP;
        cfg_data  <= top[15:0];
        @(posedge clk);
        // bit 15 of a size register is unused, toggle it anyway
        cfg_index <= glrm_pkg::CFG_MEDIA_WIDTH;
        cfg_data  <= {1'($urandom_range(1)), w[14:0]};
        @(posedge clk);
        cfg_index <= glrm_pkg::CFG_MEDIA_HEIGHT;
        cfg_data  <= {1'($urandom_range(1)), h[14:0]};
        @(posedge clk);
        cfg_index <= glrm_pkg::CFG_PAGE_NUMBER;
        cfg_data  <= page;
        @(posedge clk);
        cfg_write <= 1'b0;
        page_left = int'($signed(left[15:0]));
        page_top  = int'($signed(top[15:0]));
    endtask

    // One selection range: mostly text lines, some breaks and noise, closed by a
    // final glyph or a look-ahead glyph.
    task automatic send_range();
        int               n;
        int               lh;
        int               base_x;
        int               pen_x;
        int               pen_y;
        int               w;
        int               h;
        int               k;
        bit               look;
        glrm_pkg::glyph_t g;
        n      = $urandom_range(1, 12);
        lh     = ($urandom_range(9) == 0) ? $urandom_range(1, 3000) : $urandom_range(1, 40);
        base_x = page_left + $urandom_range(0, 200) - 20;
        pen_x  = base_x;
        pen_y  = page_top + $urandom_range(0, 300) - 20;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 6) begin
                g = {$urandom, $urandom};
            end
            else if (k < 12) begin
                g         = {$urandom, $urandom};
                g.glyph_x = '0;
                g.glyph_w = '0;
            end
            else begin
                if (k < 22) begin
                    pen_x = base_x;
                    pen_y = pen_y + lh + $urandom_range(0, 10) - 3;
                end
                w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 30);
                h = ($urandom_range(19) == 0) ? 0 : lh + $urandom_range(0, 4);
                g.glyph_x = pen_x[15:0];
                g.glyph_y = 16'(pen_y + $urandom_range(0, 6) - 3);
                g.glyph_w = w[14:0];
                g.glyph_h = h[14:0];
                pen_x     = pen_x + w + $urandom_range(0, 5);
            end
            g.lookahead_only = 1'b0;
            g.last_glyph     = 1'b0;
            if (i == n - 1) begin
                look = ($urandom_range(3) == 0);
                if (look) begin
                    // often lands inside the run so it clips it
                    g.glyph_x        = 16'(pen_x - $urandom_range(0, 60));
                    g.lookahead_only = 1'b1;
                    g.last_glyph     = 1'($urandom_range(1));
                end
                else begin
                    g.last_glyph = 1'b1;
                end
            end
            send_glyph(g);
        end
    endtask

    initial begin
        int mark;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset media box is empty: only the end marker comes out
        send_box(10, 10, 20, 20);
        send_box(40, 10, 20, 20, 1'b0, 1'b1);
        wait_idle();

        set_page(-1000, -1000, 32767, 32767, 16'h1234);
        send_box(100, 100, 50, 20);
        send_box(150, 102, 40, 20);
        send_box(300, 500, 30, 20);                     // new line, no clip
        send_box(0, 0, 0, 0);                           // break
        send_box(10, 10, 100, 30);
        send_box(50, 12, 20, 30, 1'b1, 1'b0);           // look-ahead clips, ends range
        send_box(-32768, -32768, 32767, 32767);
        send_box(32767, 32767, 32767, 32767);
        send_box(0, 0, 0, 0);                           // run off the page is dropped
        send_box(5, 5, 0, 10);                          // empty glyph, no run open
        send_box(20, 5, 10, 10);
        send_box(25, 6, 0, 10);                         // empty glyph adds nothing
        send_box(30, 5, 10, 10, 1'b0, 1'b1);
        send_box(-1500, 0, 30000, 100);                 // crosses the left media edge
        send_box(10000, 0, 30000, 100);                 // width saturates
        send_box(0, 20000, 10, 100, 1'b0, 1'b1);        // two lines from one glyph
        send_box(7, 7, 7, 7, 1'b1, 1'b0);               // look-ahead with no run
        send_box(1000, 1000, 500, 40);
        send_box(1200, 1010, 10, 10, 1'b1, 1'b1);
        send_box(100, 100, 200, 20);
        send_box(150, 115, 10, 40);                     // line change starting inside
        send_box(0, 0, 0, 0, 1'b0, 1'b1);               // break as final glyph

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (p)
                0: set_page(-32768, -32768, 32767, 32767, 16'hFFFF);
                1: set_page(32767, 32767, 32767, 32767, 16'h0000);
                2: set_page(-20, -20, 1, 1, 16'($urandom));
                default: set_page($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                                  $urandom_range(1, 4000), $urandom_range(1, 4000),
                                  16'($urandom));
            endcase
            mark = beats_sent;
            while (beats_sent - mark < 75)
                send_range();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
